// ===== hdl/jpt_pkg.sv =====
// ============================================================================
// jpt_pkg
// Shared types and constants of the joint pose transform: datapath widths,
// CORDIC arctangent table, gain correction and the sideband structs.
// ============================================================================
`default_nettype none

package jpt_pkg;

  // CORDIC x/y width: covers the Q32.16 scaled bone vector with gain growth
  localparam int DW = 50;
  // CORDIC angle width: 32-bit binary angle plus headroom
  localparam int ZW = 34;
  localparam int TABLE_LEN = 31;

  localparam logic [31:0] GAIN_CORR = 32'h9B74_EDA8;
  localparam logic signed [ZW-1:0] Z_QUARTER = 34'sd1073741824;
  localparam logic [15:0] HALF_TURN = 16'h8000;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1,
    32'd1
  };

  typedef enum logic [1:0] {
    KIND_L2W = 2'd0,
    KIND_W2L = 2'd1,
    KIND_INV = 2'd2
  } jpt_kind_e;

  // per-stage control: valid bit and CORDIC direction rule
  typedef struct packed {
    logic valid;
    logic vec;
  } jpt_ctl_t;

  // fields that ride alongside the CORDIC
  typedef struct packed {
    jpt_kind_e          kind;
    logic [15:0]        wa;
    logic [15:0]        orot;
    logic signed [31:0] lt;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
  } jpt_side_t;

endpackage

`default_nettype wire

// ===== hdl/jpt_in_if.sv =====
// ============================================================================
// jpt_in_if
// Input channel of the joint pose transform: one pose item per handshake.
// ============================================================================
`default_nettype none

interface jpt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] src_x;
  logic signed [31:0] src_y;
  logic signed [15:0] src_angle;
  logic signed [31:0] local_trans;
  logic signed [15:0] local_rot;
  logic signed [31:0] dst_x;
  logic signed [31:0] dst_y;
  logic signed [15:0] dst_angle;

  modport source (
    output valid, kind, src_x, src_y, src_angle, local_trans, local_rot,
           dst_x, dst_y, dst_angle,
    input  ready
  );

  modport sink (
    input  valid, kind, src_x, src_y, src_angle, local_trans, local_rot,
           dst_x, dst_y, dst_angle,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/jpt_out_if.sv =====
// ============================================================================
// jpt_out_if
// Result channel of the joint pose transform: one result item per handshake.
// ============================================================================
`default_nettype none

interface jpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [15:0] world_angle;
  logic signed [31:0] out_trans;
  logic signed [15:0] out_rot;

  modport source (
    output valid, world_x, world_y, world_angle, out_trans, out_rot,
    input  ready
  );

  modport sink (
    input  valid, world_x, world_y, world_angle, out_trans, out_rot,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/jpt_cordic.sv =====
// ============================================================================
// jpt_cordic
// Unrolled CORDIC, one register stage per iteration. Rotation mode steers by
// the sign of the residual angle, vectoring mode by the sign of y.
// ============================================================================
`default_nettype none

module jpt_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire jpt_pkg::jpt_ctl_t           ctl_i,
  input  wire jpt_pkg::jpt_side_t          side_i,
  input  wire logic signed [jpt_pkg::DW-1:0] x_i,
  input  wire logic signed [jpt_pkg::DW-1:0] y_i,
  input  wire logic signed [jpt_pkg::ZW-1:0] z_i,
  output jpt_pkg::jpt_ctl_t                ctl_o,
  output jpt_pkg::jpt_side_t               side_o,
  output logic signed [jpt_pkg::DW-1:0]    x_o,
  output logic signed [jpt_pkg::DW-1:0]    y_o
);

  jpt_pkg::jpt_ctl_t                ctl_s  [STEPS+1];
  jpt_pkg::jpt_side_t               side_s [STEPS+1];
  logic signed [jpt_pkg::DW-1:0]    x_s    [STEPS+1];
  logic signed [jpt_pkg::DW-1:0]    y_s    [STEPS+1];
  logic signed [jpt_pkg::ZW-1:0]    z_s    [STEPS+1];

  assign ctl_s[0]  = ctl_i;
  assign side_s[0] = side_i;
  assign x_s[0]    = x_i;
  assign y_s[0]    = y_i;
  assign z_s[0]    = z_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic signed [jpt_pkg::ZW-1:0] ATAN_Z =
      $signed({{(jpt_pkg::ZW-32){1'b0}}, jpt_pkg::ATAN_TAB[i]});

    logic signed [jpt_pkg::DW-1:0] xs, ys, x_q, y_q;
    logic signed [jpt_pkg::ZW-1:0] z_q;
    jpt_pkg::jpt_ctl_t             ctl_q;
    jpt_pkg::jpt_side_t            side_q;
    logic                          turn_pos;

    always_comb begin
      xs = x_s[i] >>> i;
      ys = y_s[i] >>> i;
      // vectoring drives y towards zero, rotation drives z towards zero
      turn_pos = ctl_s[i].vec ? y_s[i][jpt_pkg::DW-1] : !z_s[i][jpt_pkg::ZW-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q <= '0;
      end else if (en_i) begin
        ctl_q <= ctl_s[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q <= side_s[i];
        if (turn_pos) begin
          x_q <= x_s[i] - ys;
          y_q <= y_s[i] + xs;
          z_q <= z_s[i] - ATAN_Z;
        end else begin
          x_q <= x_s[i] + ys;
          y_q <= y_s[i] - xs;
          z_q <= z_s[i] + ATAN_Z;
        end
      end
    end

    assign ctl_s[i+1]  = ctl_q;
    assign side_s[i+1] = side_q;
    assign x_s[i+1]    = x_q;
    assign y_s[i+1]    = y_q;
    assign z_s[i+1]    = z_q;
  end

  assign ctl_o  = ctl_s[STEPS];
  assign side_o = side_s[STEPS];
  assign x_o    = x_s[STEPS];
  assign y_o    = y_s[STEPS];

endmodule

`default_nettype wire

// ===== hdl/joint_pose_transform.sv =====
// ============================================================================
// joint_pose_transform
// 2D skeletal joint pose conversion: local to world, world to local and pose
// inversion, with rotation and distance on one unrolled CORDIC.
// ============================================================================
// A taken item passes through the first front stage, then the second front
//   stage, one stage per CORDIC iteration, two back stages and the output
//   register.
// Throughput: one item per cycle while in_i.ready is high; the unrolled CORDIC stages set that figure.
// in_i.ready drops only while both the output register and its skid stage
//   hold results.
// Reset clears the valid bits; payload registers are not reset.
`default_nettype none

module joint_pose_transform #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input wire       clk_i,
  input wire       rst_ni,
  jpt_in_if.sink   in_i,
  jpt_out_if.source out_o
);

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [15:0] world_angle;
    logic signed [31:0] out_trans;
    logic signed [15:0] out_rot;
  } res_t;

  localparam logic signed [32:0] CG_S  = {1'b0, jpt_pkg::GAIN_CORR};
  localparam logic [15:0]        CG_HI = jpt_pkg::GAIN_CORR[31:16];
  localparam logic [15:0]        CG_LO = jpt_pkg::GAIN_CORR[15:0];
  localparam int                 DW    = jpt_pkg::DW;
  localparam int                 ZW    = jpt_pkg::ZW;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -36'sh0_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  logic en;
  logic o_valid_q, s_valid_q;
  res_t o_q, s_q;

  assign en         = !s_valid_q;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: angle sums, position differences, gain-scaled bone length
  // --------------------------------------------------------------------------
  logic               s1_valid_q;
  jpt_pkg::jpt_kind_e s1_kind_q, s1_kind_d;
  logic [15:0]        s1_wa_q, s1_orot_q, s1_orot_d;
  logic signed [31:0] s1_lt_q, s1_sx_q, s1_sy_q;
  logic signed [32:0] s1_dx_q, s1_dy_q;
  logic signed [47:0] s1_v_q;
  logic signed [64:0] s1_prod;

  always_comb begin
    s1_kind_d = jpt_pkg::jpt_kind_e'(in_i.kind);
    s1_prod   = in_i.local_trans * CG_S;
    case (s1_kind_d)
      jpt_pkg::KIND_W2L: s1_orot_d = in_i.dst_angle - in_i.src_angle;
      jpt_pkg::KIND_INV: s1_orot_d = in_i.local_rot ^ jpt_pkg::HALF_TURN;
      default:           s1_orot_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_kind_q <= s1_kind_d;
      s1_wa_q   <= in_i.src_angle + in_i.local_rot;
      s1_orot_q <= s1_orot_d;
      s1_lt_q   <= in_i.local_trans;
      s1_sx_q   <= in_i.src_x;
      s1_sy_q   <= in_i.src_y;
      s1_dx_q   <= 33'(in_i.dst_x) - 33'(in_i.src_x);
      s1_dy_q   <= 33'(in_i.dst_y) - 33'(in_i.src_y);
      s1_v_q    <= s1_prod[63:16];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: CORDIC start vector and quadrant fold
  // --------------------------------------------------------------------------
  jpt_pkg::jpt_ctl_t  s2_ctl_q, s2_ctl_d;
  jpt_pkg::jpt_side_t s2_side_q;
  logic signed [DW-1:0] s2_x_q, s2_y_q, s2_x_d, s2_y_d, s2_v, s2_dx, s2_dy;
  logic signed [ZW-1:0] s2_z_q, s2_z_d;

  always_comb begin
    s2_v   = {{(DW-48){s1_v_q[47]}}, s1_v_q};
    s2_dx  = {{(DW-41){s1_dx_q[32]}}, s1_dx_q, 8'd0};
    s2_dy  = {{(DW-41){s1_dy_q[32]}}, s1_dy_q, 8'd0};
    s2_z_d = {{(ZW-32){s1_wa_q[15]}}, s1_wa_q, 16'd0};
    s2_x_d = '0;
    s2_y_d = '0;
    s2_ctl_d.valid = s1_valid_q;
    s2_ctl_d.vec   = (s1_kind_q == jpt_pkg::KIND_W2L);
    case (s1_kind_q)
      jpt_pkg::KIND_L2W: begin
        if ($signed(s1_wa_q) >= 16'sd16384) begin
          s2_y_d = s2_v;
          s2_z_d = s2_z_d - jpt_pkg::Z_QUARTER;
        end else if ($signed(s1_wa_q) < -16'sd16384) begin
          s2_y_d = -s2_v;
          s2_z_d = s2_z_d + jpt_pkg::Z_QUARTER;
        end else begin
          s2_x_d = s2_v;
        end
      end
      jpt_pkg::KIND_W2L: begin
        // fold into the right half plane
        if (s1_dx_q[32]) begin
          s2_x_d = -s2_dx;
          s2_y_d = -s2_dy;
        end else begin
          s2_x_d = s2_dx;
          s2_y_d = s2_dy;
        end
      end
      default: begin
        s2_x_d = '0;
        s2_y_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_ctl_q <= '0;
    end else if (en) begin
      s2_ctl_q <= s2_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= '{kind: s1_kind_q, wa: s1_wa_q, orot: s1_orot_q,
                     lt: s1_lt_q, sx: s1_sx_q, sy: s1_sy_q};
      s2_x_q    <= s2_x_d;
      s2_y_q    <= s2_y_d;
      s2_z_q    <= s2_z_d;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC iterations
  // --------------------------------------------------------------------------
  jpt_pkg::jpt_ctl_t    cr_ctl;
  jpt_pkg::jpt_side_t   cr_side;
  logic signed [DW-1:0] cr_x, cr_y;

  jpt_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (s2_ctl_q),
    .side_i (s2_side_q),
    .x_i    (s2_x_q),
    .y_i    (s2_y_q),
    .z_i    (s2_z_q),
    .ctl_o  (cr_ctl),
    .side_o (cr_side),
    .x_o    (cr_x),
    .y_o    (cr_y)
  );

  // --------------------------------------------------------------------------
  // Stage A: round and add offsets; gain correction partial products
  // --------------------------------------------------------------------------
  logic                 pa_valid_q;
  jpt_pkg::jpt_side_t   pa_side_q;
  logic signed [31:0]   pa_wx_q, pa_wy_q;
  logic [57:0]          pa_phi_q, pa_plo_q;
  logic signed [DW-1:0] pa_tx, pa_ty;
  logic signed [33:0]   pa_rx, pa_ry;
  logic [41:0]          pa_ux;

  always_comb begin
    pa_tx = cr_x + DW'(32768);
    pa_ty = cr_y + DW'(32768);
    pa_rx = pa_tx[49:16];
    pa_ry = pa_ty[49:16];
    // a negative x clamps to zero; only the low 42 bits of x are kept
    pa_ux = cr_x[DW-1] ? '0 : cr_x[41:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_valid_q <= 1'b0;
    end else if (en) begin
      pa_valid_q <= cr_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_side_q <= cr_side;
      pa_wx_q   <= sat32(36'(cr_side.sx) + 36'(pa_rx));
      pa_wy_q   <= sat32(36'(cr_side.sy) + 36'(pa_ry));
      pa_phi_q  <= pa_ux * CG_HI;
      pa_plo_q  <= pa_ux * CG_LO;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: distance rounding and result selection
  // --------------------------------------------------------------------------
  logic        pb_valid_q;
  res_t        pb_q, pb_d;
  logic [58:0] pb_sum;
  logic [43:0] pb_rnd;
  logic [35:0] pb_dist;
  logic signed [31:0] pb_ot;

  always_comb begin
    pb_sum  = {1'b0, pa_phi_q} + 59'(pa_plo_q >> 16);
    pb_rnd  = {1'b0, pb_sum[58:16]} + 44'd128;
    pb_dist = pb_rnd[43:8];
    pb_ot   = (|pb_dist[35:31]) ? 32'sh7FFF_FFFF : pb_dist[31:0];
    pb_d    = '0;
    case (pa_side_q.kind)
      jpt_pkg::KIND_L2W: begin
        pb_d.world_x     = pa_wx_q;
        pb_d.world_y     = pa_wy_q;
        pb_d.world_angle = pa_side_q.wa;
      end
      jpt_pkg::KIND_W2L: begin
        pb_d.out_trans = pb_ot;
        pb_d.out_rot   = pa_side_q.orot;
      end
      jpt_pkg::KIND_INV: begin
        pb_d.out_trans = pa_side_q.lt;
        pb_d.out_rot   = pa_side_q.orot;
      end
      default: pb_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_valid_q <= 1'b0;
    end else if (en) begin
      pb_valid_q <= pa_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q <= pb_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  logic push, pop;

  assign push = en && pb_valid_q;
  assign pop  = o_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (s_valid_q) begin
      if (pop) begin
        s_valid_q <= 1'b0;
      end
    end else if (!o_valid_q || pop) begin
      o_valid_q <= push;
    end else if (push) begin
      s_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_q) begin
      if (pop) begin
        o_q <= s_q;
      end
    end else if (!o_valid_q || pop) begin
      o_q <= pb_q;
    end else if (push) begin
      s_q <= pb_q;
    end
  end

  assign out_o.valid       = o_valid_q;
  assign out_o.world_x     = o_q.world_x;
  assign out_o.world_y     = o_q.world_y;
  assign out_o.world_angle = o_q.world_angle;
  assign out_o.out_trans   = o_q.out_trans;
  assign out_o.out_rot     = o_q.out_rot;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q |-> o_valid_q)
    else $error("skid holds an item while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_q && !out_o.ready |=> s_valid_q && $stable(s_q))
    else $error("skid item lost while the output is stalled");

  a_out_not_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(o_valid_q) |-> !$past(s_valid_q))
    else $error("output emptied while the skid still held an item");

endmodule

`default_nettype wire
